/* hdl/spq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

    localparam int CAPACITY = 64;
    localparam int TAG_BITS = 16;
    localparam int COUNT_W  = $clog2(CAPACITY + 1);
    localparam int PRIO_W   = 3;

    localparam logic [PRIO_W-1:0] PRIO_OTHER   = 3'd0;
    localparam logic [PRIO_W-1:0] PRIO_VISITOR = 3'd1;
    localparam logic [PRIO_W-1:0] PRIO_STUDENT = 3'd2;
    localparam logic [PRIO_W-1:0] PRIO_SCHOLAR = 3'd3;
    localparam logic [PRIO_W-1:0] PRIO_FACULTY = 3'd4;

    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_DEQUEUE = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OVERFLOW = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;

    typedef struct packed {
        logic        operation;
        logic [15:0] entry_tag;
        logic [2:0]  entry_priority;
    } req_word_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] out_tag;
        logic [2:0]  out_priority;
        logic [6:0]  occupancy;
    } rsp_word_t;

    typedef struct packed {
        logic [TAG_BITS-1:0] tag;
        logic [PRIO_W-1:0]   prio;
    } entry_t;

    // broadcast to every cell of the row
    typedef struct packed {
        logic   enq;
        logic   deq;
        entry_t new_entry;
    } cell_ctrl_t;

endpackage

`default_nettype wire

/* hdl/spq_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module spq_cell (
    input  wire logic                clk,
    input  wire spq_pkg::cell_ctrl_t ctrl,
    input  wire logic                occupied,
    input  wire logic                left_keep,
    input  wire spq_pkg::entry_t     left_entry,
    input  wire spq_pkg::entry_t     right_entry,
    output logic                     keep,
    output spq_pkg::entry_t          entry
);

    spq_pkg::entry_t entry_reg;
    spq_pkg::entry_t entry_next;

    // an occupied cell at or above the new priority stays put on insert
    assign keep = occupied && (entry_reg.prio >= ctrl.new_entry.prio);

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.enq)
        begin
            if (keep)
                entry_next = entry_reg;
            else if (left_keep)
                entry_next = ctrl.new_entry;
            else
                entry_next = left_entry;
        end
        else if (ctrl.deq)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

`default_nettype wire

/* hdl/stable_priority_queue_core.sv */
// Stable bounded priority queue, held as a row of cells kept sorted by
// priority (highest first) and, within a priority, by arrival order.
// req channel: one word per item, operation enqueue or dequeue, with tag and
// priority for an enqueue. rsp channel: one word per accepted item, with
// status, the removed tag and priority on a good dequeue, and occupancy.
// An enqueue slides the new entry in behind every held entry of equal or
// higher priority; a dequeue takes the head cell and the row shifts forward.
// rsp_valid rises in the cycle after acceptance; one item per cycle is
// sustained while rsp_ready is high. The response register frees as it is
// taken, so req_ready holds high while rsp_ready is high. When the receiver
// stalls, the held word waits in the response register and req_ready drops
// until it is taken. A full queue refuses an enqueue with overflow; an empty
// queue answers a dequeue with empty. Priorities 5 to 7 are stored as 0.
// Reset empties the queue and the response register; cell contents are not
// cleared and are never read beyond the fill count.
`timescale 1ns / 1ps
`default_nettype none

module stable_priority_queue_core (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_ready,
    input  wire spq_pkg::req_word_t req,
    output logic                    rsp_valid,
    input  wire logic               rsp_ready,
    output spq_pkg::rsp_word_t      rsp
);

    logic [spq_pkg::COUNT_W-1:0] count_reg;
    logic [spq_pkg::COUNT_W-1:0] count_next;
    logic                        rsp_valid_reg;
    logic                        rsp_valid_next;
    spq_pkg::rsp_word_t          rsp_reg;
    spq_pkg::rsp_word_t          rsp_next;

    logic                 accept;
    logic                 full;
    logic                 empty;
    logic [spq_pkg::PRIO_W-1:0] norm_prio;
    spq_pkg::cell_ctrl_t  ctrl;

    logic            keep_w  [spq_pkg::CAPACITY];
    spq_pkg::entry_t entry_w [spq_pkg::CAPACITY];

    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign accept    = req_valid && req_ready;
    assign full      = (count_reg == spq_pkg::COUNT_W'(spq_pkg::CAPACITY));
    assign empty     = (count_reg == '0);
    assign norm_prio = (req.entry_priority > spq_pkg::PRIO_FACULTY)
                       ? spq_pkg::PRIO_OTHER : req.entry_priority;

    always_comb
    begin
        ctrl.enq           = accept && (req.operation == spq_pkg::OP_ENQUEUE) && !full;
        ctrl.deq           = accept && (req.operation == spq_pkg::OP_DEQUEUE) && !empty;
        ctrl.new_entry.tag  = req.entry_tag[spq_pkg::TAG_BITS-1:0];
        ctrl.new_entry.prio = norm_prio;
    end

    genvar gi;
    generate
        for (gi = 0; gi < spq_pkg::CAPACITY; gi++)
        begin : g_cell
            logic            occ;
            logic            lkeep;
            spq_pkg::entry_t lentry;
            spq_pkg::entry_t rentry;

            assign occ = (count_reg > spq_pkg::COUNT_W'(gi));

            if (gi == 0)
            begin : g_head
                assign lkeep  = 1'b1;
                assign lentry = entry_w[gi];
            end
            else
            begin : g_body
                assign lkeep  = keep_w[gi-1];
                assign lentry = entry_w[gi-1];
            end

            if (gi == spq_pkg::CAPACITY - 1)
            begin : g_tail
                assign rentry = entry_w[gi];
            end
            else
            begin : g_inner
                assign rentry = entry_w[gi+1];
            end

            spq_cell u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .occupied    (occ),
                .left_keep   (lkeep),
                .left_entry  (lentry),
                .right_entry (rentry),
                .keep        (keep_w[gi]),
                .entry       (entry_w[gi])
            );
        end
    endgenerate

    always_comb
    begin
        count_next     = count_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;
        if (ctrl.enq)
            count_next = count_reg + 1'b1;
        else if (ctrl.deq)
            count_next = count_reg - 1'b1;

        if (accept)
        begin
            rsp_valid_next        = 1'b1;
            rsp_next.status       = spq_pkg::ST_OK;
            rsp_next.out_tag      = '0;
            rsp_next.out_priority = '0;
            rsp_next.occupancy    = 7'(count_next);
            if (req.operation == spq_pkg::OP_ENQUEUE)
            begin
                if (full)
                    rsp_next.status = spq_pkg::ST_OVERFLOW;
            end
            else if (empty)
            begin
                rsp_next.status = spq_pkg::ST_EMPTY;
            end
            else
            begin
                rsp_next.out_tag      = 16'(entry_w[0].tag);
                rsp_next.out_priority = entry_w[0].prio;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

/* test/spq_checker.sv */
`timescale 1ns / 1ps

module spq_checker
    import spq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    input  logic      req_ready,
    input  req_word_t req,
    input  logic      rsp_valid,
    input  logic      rsp_ready,
    input  rsp_word_t rsp,
    output int        fail_count,
    output int        pending,
    output int        n_overflow,
    output int        n_empty,
    output int        peak_occupancy
);

    // entries held, oldest first, and answers still owed on the rsp channel
    entry_t    held[$];
    rsp_word_t awaited[$];

    task automatic report_mismatch(input string msg);
        if (fail_count < 50)
            $display("MISMATCH at %0t ns: %s", $realtime, msg);
        fail_count++;
    endtask

    task automatic check_field(input string name, input logic [15:0] want_v,
                               input logic [15:0] got_v);
        if (got_v !== want_v)
            report_mismatch($sformatf("%s expected %0d, got %0d", name, want_v, got_v));
    endtask

    function automatic rsp_word_t queue_answer(input req_word_t w);
        rsp_word_t         r;
        logic [PRIO_W-1:0] p;
        int                best;
        int                i;
        r = '0;
        if (w.operation == OP_ENQUEUE) begin
            p = (w.entry_priority > PRIO_FACULTY) ? PRIO_OTHER : w.entry_priority;
            if (held.size() >= CAPACITY) begin
                r.status = ST_OVERFLOW;
            end
            else begin
                held.push_back('{tag: w.entry_tag[TAG_BITS-1:0], prio: p});
                r.status = ST_OK;
            end
        end
        else if (held.size() == 0) begin
            r.status = ST_EMPTY;
        end
        else begin
            // first of the highest priority wins, so equal priorities leave in order
            best = 0;
            for (i = 1; i < held.size(); i++)
                if (held[i].prio > held[best].prio)
                    best = i;
            r.status       = ST_OK;
            r.out_tag      = held[best].tag;
            r.out_priority = held[best].prio;
            held.delete(best);
        end
        r.occupancy = 7'(held.size());
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        rsp_word_t want;
        if (!rst_n) begin
            held.delete();
            awaited.delete();
            fail_count     = 0;
            pending        = 0;
            n_overflow     = 0;
            n_empty        = 0;
            peak_occupancy = 0;
        end
        else begin
            // a word taken this edge can only answer an earlier request
            if (rsp_valid && rsp_ready) begin
                if (awaited.size() == 0) begin
                    report_mismatch("response word with no request outstanding");
                end
                else begin
                    want = awaited.pop_front();
                    check_field("status", 16'(want.status), 16'(rsp.status));
                    check_field("out_tag", want.out_tag, rsp.out_tag);
                    check_field("out_priority", 16'(want.out_priority),
                                16'(rsp.out_priority));
                    check_field("occupancy", 16'(want.occupancy), 16'(rsp.occupancy));
                    if (want.status == ST_OVERFLOW)
                        n_overflow++;
                    if (want.status == ST_EMPTY)
                        n_empty++;
                end
            end
            if (req_valid && req_ready) begin
                awaited.push_back(queue_answer(req));
                if (held.size() > peak_occupancy)
                    peak_occupancy = held.size();
            end
            pending = awaited.size();
        end
    end

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps

module tb;

    import spq_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 160;
    localparam int PHASE_ITEMS = 445;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_ready;
    req_word_t req = '0;
    logic      rsp_valid;
    logic      rsp_ready = 1'b0;
    rsp_word_t rsp;

    int fail_count;
    int pending;
    int n_overflow;
    int n_empty;
    int peak_occupancy;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_seq = 0;
    int hold_seen = 0;
    int stall_left = 0;
    int cycle_count = 0;
    int items_sent = 0;

    stable_priority_queue_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    spq_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_ready      (req_ready),
        .req            (req),
        .rsp_valid      (rsp_valid),
        .rsp_ready      (rsp_ready),
        .rsp            (rsp),
        .fail_count     (fail_count),
        .pending        (pending),
        .n_overflow     (n_overflow),
        .n_empty        (n_empty),
        .peak_occupancy (peak_occupancy)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("stable_priority_queue_core test failed");
            $finish;
        end
    end

    // receiver: random back-pressure, plus a long hold-off on request
    always @(negedge clk)
    begin
        if (hold_seq != hold_seen)
        begin
            hold_seen  = hold_seq;
            stall_left = HOLD_CYCLES;
        end
        if (stall_left > 0)
        begin
            stall_left--;
            rsp_ready <= 1'b0;
        end
        else
        begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // entered and left at a falling edge; valid stays up into the next word
    task automatic send_word(input req_word_t w);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= w;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_op(input logic op, input logic [15:0] tag, input logic [2:0] pr);
        req_word_t w;
        w.operation      = op;
        w.entry_tag      = tag;
        w.entry_priority = pr;
        send_word(w);
    endtask

    task automatic drain_wait();
        req_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
    endtask

    function automatic req_word_t random_word(input int enq_pct);
        req_word_t w;
        w.operation = ($urandom_range(99) < enq_pct) ? OP_ENQUEUE : OP_DEQUEUE;
        w.entry_tag = 16'($urandom);
        // out-of-range priorities now and then
        if ($urandom_range(9) == 0)
            w.entry_priority = 3'($urandom_range(7, 5));
        else
            w.entry_priority = 3'($urandom_range(4));
        return w;
    endfunction

    // runs of enqueue-heavy and dequeue-heavy traffic walk the fill level
    // from empty to full and back; the first two runs force both ends
    task automatic run_phase(input int n_items);
        int mix[5];
        int done;
        int seg;
        int seg_len;
        int enq_pct;
        int k;
        mix  = '{10, 35, 50, 65, 90};
        done = 0;
        seg  = 0;
        while (done < n_items)
        begin
            if (seg == 0)
            begin
                enq_pct = 95;
                seg_len = 100;
            end
            else if (seg == 1)
            begin
                enq_pct = 8;
                seg_len = 100;
            end
            else
            begin
                enq_pct = mix[$urandom_range(4)];
                seg_len = $urandom_range(30, 120);
            end
            for (k = 0; k < seg_len && done < n_items; k++)
            begin
                send_word(random_word(enq_pct));
                done++;
            end
            seg++;
        end
    endtask

    initial
    begin
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_idle_pct <= 20;
        recv_idle_pct <= 20;
        send_op(OP_DEQUEUE, 16'h5A5A, 3'd7);
        send_op(OP_ENQUEUE, 16'h0000, PRIO_OTHER);
        send_op(OP_ENQUEUE, 16'hFFFF, PRIO_FACULTY);
        send_op(OP_ENQUEUE, 16'h1234, PRIO_FACULTY);
        send_op(OP_ENQUEUE, 16'h0001, PRIO_STUDENT);
        send_op(OP_ENQUEUE, 16'hAAAA, 3'd5);
        send_op(OP_ENQUEUE, 16'h5555, 3'd6);
        send_op(OP_ENQUEUE, 16'h8000, 3'd7);
        send_op(OP_ENQUEUE, 16'h0F0F, PRIO_VISITOR);
        send_op(OP_ENQUEUE, 16'hF0F0, PRIO_SCHOLAR);
        send_op(OP_ENQUEUE, 16'h7FFF, PRIO_STUDENT);
        repeat (11)
            send_op(OP_DEQUEUE, 16'($urandom), 3'($urandom));
        drain_wait();

        // receiver mostly stalled, with one long hold-off while words keep coming
        send_idle_pct <= 7;
        recv_idle_pct <= 70;
        hold_seq      <= hold_seq + 1;
        run_phase(PHASE_ITEMS);
        drain_wait();

        send_idle_pct <= 70;
        recv_idle_pct <= 7;
        run_phase(PHASE_ITEMS);
        drain_wait();

        send_idle_pct <= 0;
        recv_idle_pct <= 0;
        run_phase(PHASE_ITEMS);
        drain_wait();
        repeat (8) @(negedge clk);

        $display("Sent %0d requests; %0d overflow and %0d empty answers, peak fill %0d of %0d.",
                 items_sent, n_overflow, n_empty, peak_occupancy, CAPACITY);
        $display("Traffic ran with sender/receiver idling 7/70, 70/7 and none, plus a hold-off.");
        if (fail_count == 0)
            $display("stable_priority_queue_core test passed");
        else
            $display("stable_priority_queue_core test failed");
        $finish;
    end

endmodule
